// ===== rtl/esd_pkg.sv =====
// Shared types and constants of the event surface decay block.
`default_nettype none
package esd_pkg;

  localparam int DefMaxWidth  = 1024;
  localparam int DefMaxHeight = 512;
  localparam int DefMaxRadius = 15;

  localparam int RadiusW    = 4;
  localparam int FactorW    = 16;
  localparam int WidthCfgW  = 11;
  localparam int HeightCfgW = 10;
  localparam int PosXW      = 10;
  localparam int PosYW      = 9;
  localparam int PixelW     = 8;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;
  localparam int CoordW     = 13;

  localparam logic [RadiusW-1:0]    RstRadius = 4'd7;
  localparam logic [FactorW-1:0]    RstFactor = 16'd55181;
  localparam logic [WidthCfgW-1:0]  RstWidth  = 11'd640;
  localparam logic [HeightCfgW-1:0] RstHeight = 10'd480;

  localparam logic [PixelW-1:0] PixelFull = 8'hFF;
  localparam logic [PixelW-1:0] PixelZero = 8'h00;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRadius = 2'd0,
    CfgFactor = 2'd1,
    CfgWidth  = 2'd2,
    CfgHeight = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    WrNone  = 2'd0,
    WrZero  = 2'd1,
    WrDecay = 2'd2,
    WrFull  = 2'd3
  } wr_op_e;

  typedef struct packed {
    logic   rd_en;
    wr_op_e wr_op;
  } mem_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/esd_surface.sv =====
// Surface memory with registered read and the decay multiplier on its write path.
`default_nettype none
module esd_surface #(
  parameter int Depth = 524288,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic                          clk_i,
  input  wire esd_pkg::mem_ctl_t             ctl_i,
  input  wire logic [AddrW-1:0]              rd_addr_i,
  input  wire logic [AddrW-1:0]              wr_addr_i,
  input  wire logic [esd_pkg::FactorW-1:0]   factor_i,
  output logic      [esd_pkg::PixelW-1:0]    rd_data_o
);
  import esd_pkg::*;

  logic [PixelW-1:0]         mem_q [Depth];
  logic [PixelW-1:0]         rd_data_q;
  logic [PixelW+FactorW-1:0] product;
  logic [PixelW-1:0]         wr_data;
  logic                      wr_en;

  assign product = {{FactorW{1'b0}}, rd_data_q} * {{PixelW{1'b0}}, factor_i};

  always_comb begin
    wr_en   = 1'b1;
    wr_data = PixelZero;
    case (ctl_i.wr_op)
      WrZero:  wr_data = PixelZero;
      WrDecay: wr_data = product[PixelW+FactorW-1:FactorW];
      WrFull:  wr_data = PixelFull;
      default: wr_en   = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr_i] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ===== rtl/eros_event_surface_decay.sv =====
// Top level of the event surface decay block: sequencer, window counters and ports.
//
//   channel | signals                                   | direction
//   input   | in_valid_i, in_stall_o, req_type_i, pos_*  | event or read request in
//   output  | out_valid_o, out_stall_i, pixel_value_o    | read result out
//   config  | cfg_valid_i, cfg_ready_o, cfg_index_i/data | register write
//
// An event inside the configured size sweeps its clipped window: one read-modify-write
// of the surface memory per cycle through its single read and write port, then the set.
// A read waits in StRwait while the output register is held by out_stall_i.
// After reset the memory is cleared one pixel per cycle, all MAX_WIDTH*MAX_HEIGHT
// pixels (524288 by default); in_stall_o stays high meanwhile.
// Config writes are taken every cycle.
`default_nettype none
module eros_event_surface_decay #(
  parameter int MAX_WIDTH  = esd_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = esd_pkg::DefMaxHeight,
  parameter int MAX_RADIUS = esd_pkg::DefMaxRadius
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          req_type_i,
  input  wire logic [esd_pkg::PosXW-1:0]     pos_x_i,
  input  wire logic [esd_pkg::PosYW-1:0]     pos_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [esd_pkg::PixelW-1:0]    pixel_value_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [esd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [esd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import esd_pkg::*;

  localparam int Depth   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW   = $clog2(Depth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  typedef enum logic [8:0] {
    StClear = 9'b000000001,
    StIdle  = 9'b000000010,
    StSetup = 9'b000000100,
    StRead  = 9'b000001000,
    StRwait = 9'b000010000,
    StBase  = 9'b000100000,
    StSweep = 9'b001000000,
    StDrain = 9'b010000000,
    StSet   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [RadiusW-1:0]    radius_q;
  logic [FactorW-1:0]    factor_q;
  logic [WidthCfgW-1:0]  width_q;
  logic [HeightCfgW-1:0] height_q;

  logic             req_q, req_d;
  logic [PosXW-1:0] px_q, px_d;
  logic [PosYW-1:0] py_q, py_d;
  logic             inside_q, inside_d;
  logic [CoordW-1:0] x0_q, x0_d, x1_q, x1_d, y0_q, y0_d, y1_q, y1_d;
  logic [CoordW-1:0] x_q, x_d, y_q, y_d;
  logic [AddrW-1:0]  row_base_q, row_base_d;
  logic [AddrW-1:0]  ev_addr_q, ev_addr_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [AddrW-1:0]  s1_addr_q, s1_addr_d;
  logic              s1_valid_q, s1_valid_d;
  logic              out_valid_q, out_valid_d;
  logic [PixelW-1:0] pixel_q, pixel_d;

  logic [CoordW-1:0] w, h, r, pxc, pyc, xe, ye;
  logic [AddrW-1:0]  sweep_addr, rd_addr, wr_addr;
  logic [PixelW-1:0] rd_data;
  mem_ctl_t          ctl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RstRadius;
      factor_q <= RstFactor;
      width_q  <= RstWidth;
      height_q <= RstHeight;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgRadius: radius_q <= cfg_data_i[RadiusW-1:0];
        CfgFactor: factor_q <= cfg_data_i[FactorW-1:0];
        CfgWidth:  width_q  <= cfg_data_i[WidthCfgW-1:0];
        CfgHeight: height_q <= cfg_data_i[HeightCfgW-1:0];
        default: ;
      endcase
    end
  end

  assign pxc = CoordW'(px_q);
  assign pyc = CoordW'(py_q);
  assign w = (CoordW'(width_q) > CoordW'(MAX_WIDTH)) ? CoordW'(MAX_WIDTH) : CoordW'(width_q);
  assign h = (CoordW'(height_q) > CoordW'(MAX_HEIGHT)) ?
             CoordW'(MAX_HEIGHT) : CoordW'(height_q);
  assign r = (CoordW'(radius_q) > CoordW'(MAX_RADIUS)) ?
             CoordW'(MAX_RADIUS) : CoordW'(radius_q);
  assign xe = pxc + r;
  assign ye = pyc + r;
  assign sweep_addr = row_base_q + AddrW'(x_q);

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    px_d        = px_q;
    py_d        = py_q;
    inside_d    = inside_q;
    x0_d        = x0_q;
    x1_d        = x1_q;
    y0_d        = y0_q;
    y1_d        = y1_q;
    x_d         = x_q;
    y_d         = y_q;
    row_base_d  = row_base_q;
    ev_addr_d   = ev_addr_q;
    clr_d       = clr_q;
    s1_valid_d  = 1'b0;
    s1_addr_d   = sweep_addr;
    out_valid_d = out_valid_q && out_stall_i;
    pixel_d     = pixel_q;
    ctl.rd_en   = 1'b0;
    ctl.wr_op   = s1_valid_q ? WrDecay : WrNone;
    rd_addr     = ev_addr_q;
    wr_addr     = s1_addr_q;

    case (state_q)
      StClear: begin
        ctl.wr_op = WrZero;
        wr_addr   = clr_q;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == LastAddr) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          req_d   = req_type_i;
          px_d    = pos_x_i;
          py_d    = pos_y_i;
          state_d = StSetup;
        end
      end
      StSetup: begin
        inside_d  = (pxc < w) && (pyc < h);
        x0_d      = (pxc > r) ? pxc - r : '0;
        y0_d      = (pyc > r) ? pyc - r : '0;
        x1_d      = (xe > w - CoordW'(1)) ? w - CoordW'(1) : xe;
        y1_d      = (ye > h - CoordW'(1)) ? h - CoordW'(1) : ye;
        ev_addr_d = AddrW'(py_q * MAX_WIDTH) + AddrW'(px_q);
        state_d   = req_q ? StRead : ((pxc < w) && (pyc < h)) ? StBase : StIdle;
      end
      StRead: begin
        ctl.rd_en = 1'b1;
        state_d   = StRwait;
      end
      StRwait: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          pixel_d     = inside_q ? rd_data : PixelZero;
          state_d     = StIdle;
        end
      end
      StBase: begin
        row_base_d = AddrW'(y0_q * MAX_WIDTH);
        x_d        = x0_q;
        y_d        = y0_q;
        state_d    = StSweep;
      end
      StSweep: begin
        ctl.rd_en  = 1'b1;
        rd_addr    = sweep_addr;
        s1_valid_d = 1'b1;
        if (x_q == x1_q) begin
          x_d        = x0_q;
          y_d        = y_q + CoordW'(1);
          row_base_d = row_base_q + AddrW'(MAX_WIDTH);
          if (y_q == y1_q) begin
            state_d = StDrain;
          end
        end else begin
          x_d = x_q + CoordW'(1);
        end
      end
      StDrain: begin
        state_d = StSet;
      end
      StSet: begin
        ctl.wr_op = WrFull;
        wr_addr   = ev_addr_q;
        state_d   = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    px_q       <= px_d;
    py_q       <= py_d;
    inside_q   <= inside_d;
    x0_q       <= x0_d;
    x1_q       <= x1_d;
    y0_q       <= y0_d;
    y1_q       <= y1_d;
    x_q        <= x_d;
    y_q        <= y_d;
    row_base_q <= row_base_d;
    ev_addr_q  <= ev_addr_d;
    s1_addr_q  <= s1_addr_d;
    pixel_q    <= pixel_d;
  end

  esd_surface #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_surface (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .factor_i  (factor_q),
    .rd_data_o (rd_data)
  );

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pixel_q;

  a_decay_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(state_q == StSweep))
    else $error("decay write without a sweep read");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StRwait))
    else $error("result not caused by a read request");

  a_sweep_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSweep) |-> (x_q <= x1_q) && (y_q <= y1_q))
    else $error("sweep counter outside window");

  a_set_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSet) |-> $past(state_q == StDrain))
    else $error("event pixel set before window decay finished");

endmodule
`default_nettype wire
